FILE: design/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: design/edb_pkg.sv
`timescale 1ns / 1ps

package edb_pkg;

    localparam int PIX_W          = 8;
    localparam int SQ_W           = 2 * PIX_W;
    localparam int SUM_W          = 26;
    localparam int DIST_W         = 21;
    localparam int FRAC_W         = 8;
    localparam int RAD_W          = SUM_W + 2 * FRAC_W;
    localparam int REM_W          = DIST_W + 2;
    localparam int ROOT_STEPS     = DIST_W;
    localparam int STEP_W         = $clog2(ROOT_STEPS);
    localparam int SQ_MAX         = 65025;
    localparam int MAX_PIXELS_DEF = 1024;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum_squares;
        logic [DIST_W-1:0] distance_fixed;
        logic              too_long;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_ROOT,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic acc_en;
        logic root_start;
        logic root_step;
        logic out_load;
    } dp_cmd_t;

endpackage

FILE: design/euclidean_distance_bytes.sv
`timescale 1ns / 1ps
// a closing request (last set) passes the 21-step root unit and the output load,
//   and dst_valid rises; throughput: one pixel-pair request per cycle while
//   accumulating, a closing one if no result waits; input stalls in root and load
// reset: rst_n asynchronous active low, clears sum, count, flag and control;
//   the block accepts requests as soon as reset is released
module euclidean_distance_bytes #(
    parameter int MAX_PIXELS = edb_pkg::MAX_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  edb_pkg::in_item_t   src_data,
    input  logic                src_valid,
    output logic                src_stall,
    output edb_pkg::out_item_t  dst_data,
    output logic                dst_valid,
    input  logic                dst_stall
);
    import edb_pkg::*;

    // command bundle from the controller to the datapath
    dp_cmd_t cmd;

    // controller: accumulate state, root iteration, result load
    //   the output register decouples the two sides, so pairs of the next
    //   vector are taken while a finished result still waits downstream
    edb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_last  (src_data.last),
        .src_stall (src_stall),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .cmd       (cmd)
    );

    // datapath: squared difference, saturating accumulator with pair count,
    //   digit-by-digit square root of sum * 65536 (one root bit per cycle),
    //   output register
    edb_dpath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .src_data (src_data),
        .dst_data (dst_data)
    );

endmodule

FILE: design/edb_dpath.sv
`timescale 1ns / 1ps

module edb_dpath #(
    parameter int MAX_PIXELS = edb_pkg::MAX_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  edb_pkg::dp_cmd_t    cmd,
    input  edb_pkg::in_item_t   src_data,
    output edb_pkg::out_item_t  dst_data
);
    import edb_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam longint unsigned SUM_FULL = longint'(MAX_PIXELS) * longint'(SQ_MAX);
    localparam longint unsigned SUM_FIELD_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam logic [SUM_W-1:0] SUM_CAP =
        SUM_W'(SUM_FULL > SUM_FIELD_MAX ? SUM_FIELD_MAX : SUM_FULL);

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [SUM_W-1:0]  hold_sum_reg;
    logic              hold_ovf_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    out_item_t         out_reg;

    logic [PIX_W-1:0]  diff;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    sum_wide;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;

    // absolute difference, square, saturating add
    always_comb
    begin
        diff     = (src_data.pixel_a >= src_data.pixel_b) ?
                   src_data.pixel_a - src_data.pixel_b :
                   src_data.pixel_b - src_data.pixel_a;
        sq       = SQ_W'(diff) * SQ_W'(diff);
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq);
        if (cnt_reg >= CNT_W'(MAX_PIXELS))
        begin
            ovf_next = 1'b1;
            sum_next = SUM_CAP;
            cnt_next = cnt_reg;
        end
        else
        begin
            ovf_next = ovf_reg;
            sum_next = (sum_wide > (SUM_W + 1)'(SUM_CAP)) ? SUM_CAP : sum_wide[SUM_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // one root bit per step
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = (REM_W + 2)'({root_reg, 2'b01});
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (src_data.last)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            hold_sum_reg <= sum_next;
            hold_ovf_reg <= ovf_next;
            rad_reg      <= {sum_next, {(2 * FRAC_W){1'b0}}};
            rem_reg      <= '0;
            root_reg     <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[DIST_W-2:0], take};
        end
        if (cmd.out_load)
        begin
            out_reg.sum_squares    <= hold_sum_reg;
            out_reg.distance_fixed <= root_reg;
            out_reg.too_long       <= hold_ovf_reg;
        end
    end

    assign dst_data = out_reg;

endmodule

FILE: design/edb_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic              src_last,
    output logic              src_stall,
    output logic              dst_valid,
    input  logic              dst_stall,
    output edb_pkg::dp_cmd_t  cmd
);
    import edb_pkg::*;

    ctl_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic              src_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        cmd        = '0;
        src_stall  = 1'b1;
        src_acc    = 1'b0;
        if (valid_reg && !dst_stall)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_ACCUM:
            begin
                // a closing request waits until the output slot is free
                src_stall      = valid_reg && src_last;
                src_acc        = src_valid && !src_stall;
                cmd.acc_en     = src_acc;
                cmd.root_start = src_acc && src_last;
                if (src_acc && src_last)
                begin
                    state_next = ST_ROOT;
                    step_next  = '0;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = 1'b1;
                valid_next   = 1'b1;
                state_next   = ST_ACCUM;
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    assign dst_valid = valid_reg;

    `ASSERT_CLK(a_last_starts_root, clk, rst_n, (src_acc && src_last) |=> (state_reg == ST_ROOT))
    `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, src_acc && (state_reg != ST_ACCUM))
    `ASSERT_CLK(a_valid_from_done, clk, rst_n, $rose(valid_reg) |-> $past(state_reg == ST_DONE))
    `ASSERT_NEVER(a_root_with_result, clk, rst_n, (state_reg == ST_DONE) && valid_reg)

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import edb_pkg::*;

    // block sizing and the saturation point of the running sum
    localparam int     MAX_PIX       = MAX_PIXELS_DEF;
    localparam longint SUM_FULL      = longint'(MAX_PIX) * SQ_MAX;
    localparam longint SUM_FIELD_MAX = (longint'(1) << SUM_W) - 1;
    localparam longint SUM_CAP       = (SUM_FULL > SUM_FIELD_MAX) ? SUM_FIELD_MAX : SUM_FULL;

    // leave margin at the end
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    in_item_t    src_data = '0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    out_item_t   dst_data;
    logic        dst_valid;
    logic        dst_stall = 1'b0;

    // requests waiting to be driven, and results the predictor says are due
    in_item_t    pixel_feed[$];
    out_item_t   distance_due[$];

    // predictor copy of the block state
    logic [SUM_W:0] sum_acc = '0;
    logic [10:0]    pairs_seen = '0;
    logic           past_limit = 1'b0;

    // idling percentages, changed between phases
    int          src_idle_pct = 0;
    int          dst_stall_pct = 0;

    // set at the rising edge when the driven request was taken
    logic        src_taken = 1'b0;

    int          fail_count = 0;
    int          pairs_sent = 0;
    int          vectors_closed = 0;
    int          over_length = 0;
    int          cap_hits = 0;
    int          cycle_count = 0;

    euclidean_distance_bytes #(
        .MAX_PIXELS(MAX_PIX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_data(src_data),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .dst_data(dst_data),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // floor square root, restoring method two bits at a time
    function automatic logic [DIST_W-1:0] fixed_root(input logic [RAD_W-1:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        rem = '0;
        root = '0;
        for (int i = RAD_W / 2 - 1; i >= 0; i--)
        begin
            rem = (rem << 2) | ((v >> (2 * i)) & 2'b11);
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root[DIST_W-1:0];
    endfunction

    // fold one pixel pair into the running sum; returns 1 when a result is due
    function automatic bit fold_pixel_pair(input in_item_t p, output out_item_t res);
        logic [PIX_W-1:0] gap;
        longint           total;
        gap = (p.pixel_a >= p.pixel_b) ? p.pixel_a - p.pixel_b : p.pixel_b - p.pixel_a;
        res = '0;
        // a pair beyond the maximum length pins the sum at its cap
        if (pairs_seen >= MAX_PIX)
        begin
            past_limit = 1'b1;
            sum_acc = (SUM_W + 1)'(SUM_CAP);
        end
        else
        begin
            total = longint'(sum_acc) + longint'(gap) * longint'(gap);
            sum_acc = (total > SUM_CAP) ? (SUM_W + 1)'(SUM_CAP) : (SUM_W + 1)'(total);
            pairs_seen = pairs_seen + 1'b1;
        end
        if (!p.last)
            return 1'b0;
        res.sum_squares = sum_acc[SUM_W-1:0];
        res.distance_fixed = fixed_root({sum_acc[SUM_W-1:0], {2 * FRAC_W{1'b0}}});
        res.too_long = past_limit;
        // vector closed, start over
        sum_acc = '0;
        pairs_seen = '0;
        past_limit = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // driver: changes requests at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a held request stays put until taken
            if (!src_valid || src_taken)
            begin
                if (pixel_feed.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    src_data <= pixel_feed.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
            dst_stall <= ($urandom_range(99) < dst_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t due;
        if (rst_n)
        begin
            src_taken <= src_valid && !src_stall;

            // accepted pixel-pair request feeds the predictor
            if (src_valid && !src_stall)
            begin
                pairs_sent++;
                if (fold_pixel_pair(src_data, due))
                    distance_due = {distance_due, due};
            end

            // accepted result is checked against the oldest expectation
            if (dst_valid && !dst_stall)
            begin
                if (distance_due.size() == 0)
                begin
                    flag_mismatch("unexpected result sum_squares",
                                  dst_data.sum_squares, -1);
                end
                else
                begin
                    want = distance_due.pop_front();
                    vectors_closed++;
                    if (dst_data.sum_squares !== want.sum_squares)
                        flag_mismatch("sum_squares", dst_data.sum_squares, want.sum_squares);
                    if (dst_data.distance_fixed !== want.distance_fixed)
                        flag_mismatch("distance_fixed", dst_data.distance_fixed,
                                      want.distance_fixed);
                    if (dst_data.too_long !== want.too_long)
                        flag_mismatch("too_long", dst_data.too_long, want.too_long);
                    if (want.too_long)
                        over_length++;
                    if (want.sum_squares == SUM_CAP[SUM_W-1:0])
                        cap_hits++;
                end
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, distance_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_pair(input int a, input int b, input bit close);
        in_item_t p;
        p.pixel_a = a[PIX_W-1:0];
        p.pixel_b = b[PIX_W-1:0];
        p.last = close;
        pixel_feed = {pixel_feed, p};
    endtask

    // byte skewed toward the rails now and then
    function automatic int pick_byte();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // one vector of len pairs; full swing puts every difference at its maximum
    task automatic push_vector(input int len, input bit full_swing);
        bit coin;
        for (int i = 0; i < len; i++)
        begin
            coin = $urandom_range(1);
            if (full_swing)
                push_pair(coin ? 255 : 0, coin ? 0 : 255, i == len - 1);
            else
                push_pair(pick_byte(), pick_byte(), i == len - 1);
        end
    endtask

    // mostly short vectors, with an occasional longer one
    task automatic push_random_vectors(input int n_pairs);
        int queued;
        int len;
        queued = 0;
        while (queued < n_pairs)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            push_vector(len, 1'b0);
            queued += len;
        end
    endtask

    // blocks until every request is taken and every result has come back
    task automatic wait_drained();
        while (pixel_feed.size() > 0 || src_valid || distance_due.size() > 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // single-pair vectors at the extremes
        push_pair(0, 0, 1'b1);
        push_pair(255, 0, 1'b1);
        push_pair(0, 255, 1'b1);
        push_pair(255, 255, 1'b1);
        push_pair(1, 0, 1'b1);
        push_pair(0, 1, 1'b1);
        // short multi-pair vectors, both signs of difference
        push_pair(255, 0, 1'b0);
        push_pair(0, 255, 1'b1);
        push_pair(128, 127, 1'b0);
        push_pair(127, 128, 1'b0);
        push_pair(10, 200, 1'b0);
        push_pair(200, 10, 1'b0);
        push_pair(77, 77, 1'b1);
        wait_drained();

        // phase one: sender idles lightly, receiver stalls heavily
        src_idle_pct = 24;
        dst_stall_pct = 82;
        // vector with every difference at its maximum
        push_vector(32, 1'b1);
        push_random_vectors(50);
        wait_drained();

        // phase two: the other way round, with an over-length vector
        src_idle_pct = 82;
        dst_stall_pct = 24;
        push_random_vectors(20);
        push_vector($urandom_range(MAX_PIX + 1, MAX_PIX + 6), 1'b0);
        push_random_vectors(20);
        wait_drained();

        // phase three: back to back in both directions
        src_idle_pct = 0;
        dst_stall_pct = 0;
        push_random_vectors(40);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixel pairs in %0d vectors over three idling patterns",
                 pairs_sent, vectors_closed);
        $display("%0d vectors ran past the length limit, %0d hit the sum ceiling",
                 over_length, cap_hits);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/edb_pkg.sv
design/edb_dpath.sv
design/edb_ctrl.sv
design/euclidean_distance_bytes.sv
sim/testbench.sv
